[rtl/drb_pkg.sv]
// Shared types, constants and helpers for the deferred return buffer pool.
// No dependencies; every other file in rtl/ but drb_ram imports this package.
package drb_pkg;

    localparam int DEF_POOL_DEPTH = 64;
    localparam int SIZE_W         = 7;
    localparam int SLOT_W         = 32;
    localparam int ENTRY_W        = 6;
    localparam int DATA_W         = 32;
    localparam int ADDR_W         = 3;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [SIZE_W-1:0] POOL_ENTRIES_RST = 7'd64;

    // register index as decoded from the word address
    localparam logic REG_POOL_ENTRIES = 1'b0;

    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_UNALLOC = 2'd1,
        FUNC_FREE    = 2'd2,
        FUNC_SWEEP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        B_IDLE       = 2'd0,
        B_ALLOC_RD   = 2'd1,
        B_SWEEP_RING = 2'd2,
        B_SWEEP_SLOT = 2'd3
    } back_state_t;

    // classified request, front -> queue -> back
    typedef struct packed {
        func_t               func;
        logic [SLOT_W-1:0]   slot;
        logic [ENTRY_W-1:0]  entry;
        logic                entry_ok;
    } op_t;

    // one result transfer
    typedef struct packed {
        logic                granted;
        logic [ENTRY_W-1:0]  entry_out;
        logic [SLOT_W-1:0]   slot_out;
        logic                slot_valid;
        logic                last;
        logic [SIZE_W-1:0]   free_count;
    } res_t;

    // pool reinitialisation request from the register block
    typedef struct packed {
        logic                en;
        logic [SIZE_W-1:0]   size;
    } init_t;

    // pool entry count saturated into 1..depth
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] sz,
                                                   input logic [SIZE_W-1:0] depth);
        logic [SIZE_W-1:0] r;
        if (sz == '0)
            r = SIZE_W'(1);
        else if (sz > depth)
            r = depth;
        else
            r = sz;
        return r;
    endfunction

endpackage

[rtl/drb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module drb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/drb_front.sv]
// Request front end: input stage that decodes the operation and range-checks the entry.
// Depends on drb_pkg.
module drb_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic [drb_pkg::SLOT_W-1:0]  slot_index,
    input  logic [drb_pkg::ENTRY_W-1:0] entry_index,
    input  logic [drb_pkg::SIZE_W-1:0]  n_size,
    input  logic                        q_ready,
    output logic                        q_push,
    output drb_pkg::op_t                q_op
);
    import drb_pkg::*;

    logic stage_valid_reg;
    logic stage_valid_next;
    op_t  op_reg;
    op_t  op_next;
    logic accept;

    assign in_ready = !stage_valid_reg || q_ready;
    assign accept   = in_valid && in_ready;
    assign q_push   = stage_valid_reg;
    assign q_op     = op_reg;

    always_comb
    begin
        op_next.func     = func_t'(func);
        op_next.slot     = slot_index;
        op_next.entry    = entry_index;
        op_next.entry_ok = {1'b0, entry_index} < n_size;

        if (accept)
            stage_valid_next = 1'b1;
        else if (q_ready)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
        end
    end

endmodule

[rtl/drb_queue.sv]
// Short FIFO of classified requests between front end and pool engine.
// Depends on drb_pkg.
module drb_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         push_ready,
    input  drb_pkg::op_t push_op,
    output logic         pop_valid,
    input  logic         pop,
    output drb_pkg::op_t pop_op
);
    import drb_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    op_t             slots_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg;
    logic [QP_W-1:0] rd_ptr_reg;
    logic [QC_W-1:0] count_reg;
    logic [QC_W-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    function automatic logic [QP_W-1:0] qadv(input logic [QP_W-1:0] p);
        return (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign push_ready = count_reg != QC_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_op     = slots_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= qadv(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= qadv(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[rtl/drb_back.sv]
// Pool engine: free ring, cursors, counts, slot store and the result register.
// Depends on drb_pkg and drb_ram.
module drb_back #(
    parameter int POOL_DEPTH = drb_pkg::DEF_POOL_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  drb_pkg::init_t             init,
    input  logic [drb_pkg::SIZE_W-1:0] n_size,
    input  logic                       q_valid,
    input  drb_pkg::op_t               q_op,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output drb_pkg::res_t              out_res
);
    import drb_pkg::*;

    localparam int PTR_W = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] AVAIL_RST =
        CNT_W'(eff_size(POOL_ENTRIES_RST, SIZE_W'(POOL_DEPTH)));

    back_state_t          state_reg, state_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [PTR_W-1:0]     trail_reg, trail_next;
    logic [CNT_W-1:0]     avail_reg, avail_next;
    logic [CNT_W-1:0]     ret_reg, ret_next;
    logic [POOL_DEPTH-1:0] valid_reg;
    logic                 out_valid_reg;
    res_t                 out_res_reg, res_next;
    logic [SLOT_W-1:0]    op_slot_reg, op_slot_next;
    logic                 ring_init_reg;
    logic [PTR_W-1:0]     ring_addr_reg;

    logic [CNT_W-1:0]     n;
    logic                 out_free;
    logic                 emit;
    logic                 has_out;
    logic                 free_ok;

    logic                 ring_wr_en;
    logic [PTR_W-1:0]     ring_wr_data;
    logic                 ring_rd_en;
    logic [PTR_W-1:0]     ring_rd_addr;
    logic [PTR_W-1:0]     ring_q;
    logic [PTR_W-1:0]     ring_entry;
    logic                 slot_wr_en;
    logic                 slot_rd_en;
    logic [SLOT_W-1:0]    slot_q;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                             input logic [CNT_W-1:0] sz);
        logic [SUM_W-1:0] p1;
        p1 = SUM_W'(p) + 1'b1;
        return (p1 >= SUM_W'(sz)) ? '0 : p1[PTR_W-1:0];
    endfunction

    assign n          = n_size[CNT_W-1:0];
    assign out_free   = !out_valid_reg || out_ready;
    assign has_out    = (SUM_W'(avail_reg) + SUM_W'(ret_reg)) < SUM_W'(n);
    assign free_ok    = has_out && q_op.entry_ok;
    // a ring entry never written since init holds its own index
    assign ring_entry = ring_init_reg ? ring_addr_reg : ring_q;

    // free ring: written at the tail, read at head or trail
    drb_ram #(
        .WIDTH (PTR_W),
        .DEPTH (POOL_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (tail_reg),
        .wr_data (ring_wr_data),
        .rd_en   (ring_rd_en),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_q)
    );

    // recorded ring slot per pool entry
    drb_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (POOL_DEPTH)
    ) u_slot (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (ring_entry),
        .wr_data (op_slot_reg),
        .rd_en   (slot_rd_en),
        .rd_addr (ring_entry),
        .rd_data (slot_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_op.func == FUNC_ALLOC && avail_reg != '0)
                        state_next = B_ALLOC_RD;
                    else if (q_op.func == FUNC_SWEEP && ret_reg != '0)
                        state_next = B_SWEEP_RING;
                end
            end
            B_ALLOC_RD:
            begin
                if (out_free)
                    state_next = B_IDLE;
            end
            B_SWEEP_RING:
            begin
                state_next = B_SWEEP_SLOT;
            end
            B_SWEEP_SLOT:
            begin
                if (out_free)
                    state_next = (ret_reg == CNT_W'(1)) ? B_IDLE : B_SWEEP_RING;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        q_pop        = 1'b0;
        emit         = 1'b0;
        res_next     = '0;
        res_next.last = 1'b1;
        res_next.free_count = SIZE_W'(avail_reg);
        head_next    = head_reg;
        tail_next    = tail_reg;
        trail_next   = trail_reg;
        avail_next   = avail_reg;
        ret_next     = ret_reg;
        op_slot_next = op_slot_reg;
        ring_wr_en   = 1'b0;
        ring_wr_data = q_op.entry[PTR_W-1:0];
        ring_rd_en   = 1'b0;
        ring_rd_addr = head_reg;
        slot_wr_en   = 1'b0;
        slot_rd_en   = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_op.func)
                        FUNC_ALLOC:
                        begin
                            if (avail_reg == '0)
                            begin
                                q_pop = out_free;
                                emit  = out_free;
                            end
                            else
                            begin
                                q_pop        = 1'b1;
                                op_slot_next = q_op.slot;
                                ring_rd_en   = 1'b1;
                                ring_rd_addr = head_reg;
                            end
                        end
                        FUNC_UNALLOC:
                        begin
                            q_pop = out_free;
                            emit  = out_free;
                            if (has_out && out_free)
                            begin
                                avail_next = avail_reg + 1'b1;
                                head_next  = (head_reg == '0) ?
                                             PTR_W'(n - 1'b1) : head_reg - 1'b1;
                            end
                            res_next.granted    = has_out;
                            res_next.free_count = SIZE_W'(avail_next);
                        end
                        FUNC_FREE:
                        begin
                            q_pop = out_free;
                            emit  = out_free;
                            if (free_ok && out_free)
                            begin
                                ring_wr_en = 1'b1;
                                ret_next   = ret_reg + 1'b1;
                                tail_next  = adv(tail_reg, n);
                            end
                            res_next.granted = free_ok;
                        end
                        FUNC_SWEEP:
                        begin
                            if (ret_reg == '0)
                            begin
                                q_pop = out_free;
                                emit  = out_free;
                                res_next.granted = 1'b1;
                            end
                            else
                            begin
                                q_pop        = 1'b1;
                                ring_rd_en   = 1'b1;
                                ring_rd_addr = trail_reg;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b0;
                        end
                    endcase
                end
            end
            B_ALLOC_RD:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    slot_wr_en = 1'b1;
                    avail_next = avail_reg - 1'b1;
                    head_next  = adv(head_reg, n);
                    res_next.granted    = 1'b1;
                    res_next.entry_out  = ENTRY_W'(ring_entry);
                    res_next.free_count = SIZE_W'(avail_next);
                end
            end
            B_SWEEP_RING:
            begin
                slot_rd_en = 1'b1;
            end
            B_SWEEP_SLOT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    avail_next = avail_reg + 1'b1;
                    ret_next   = ret_reg - 1'b1;
                    trail_next = adv(trail_reg, n);
                    res_next.granted    = 1'b1;
                    res_next.slot_out   = slot_q;
                    res_next.slot_valid = 1'b1;
                    res_next.last       = ret_reg == CNT_W'(1);
                    res_next.free_count = SIZE_W'(avail_next);
                    if (ret_reg != CNT_W'(1))
                    begin
                        ring_rd_en   = 1'b1;
                        ring_rd_addr = trail_next;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            trail_reg     <= '0;
            avail_reg     <= AVAIL_RST;
            ret_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (init.en)
        begin
            state_reg     <= B_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            trail_reg     <= '0;
            avail_reg     <= init.size[CNT_W-1:0];
            ret_reg       <= '0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            trail_reg <= trail_next;
            avail_reg <= avail_next;
            ret_reg   <= ret_next;
            if (ring_wr_en)
                valid_reg[tail_reg] <= 1'b1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        op_slot_reg <= op_slot_next;
        if (emit)
            out_res_reg <= res_next;
        if (ring_rd_en)
        begin
            ring_init_reg <= !valid_reg[ring_rd_addr];
            ring_addr_reg <= ring_rd_addr;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

`ifndef SYNTHESIS
    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(avail_reg) + SUM_W'(ret_reg)) <= SUM_W'(n))
        else $error("available plus returnable exceeds pool size");

    a_cursors_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(head_reg) < n) && (CNT_W'(tail_reg) < n) && (CNT_W'(trail_reg) < n))
        else $error("ring cursor outside pool");

    a_sweep_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SWEEP_RING || state_reg == B_SWEEP_SLOT) |-> ret_reg != '0)
        else $error("sweep running with nothing returnable");

    a_alloc_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_ALLOC_RD |-> avail_reg != '0)
        else $error("alloc in flight with empty pool");
`endif

endmodule

[rtl/deferred_return_buffer_pool.sv]
// Top level of the deferred return buffer pool: APB register, front end, queue, pool engine.
// Depends on drb_pkg, drb_front, drb_queue, drb_back and drb_ram.
//
// Buffer-context pool kept on a circular free ring with head, tail and trail cursors.
// Requests enter through a registered front end that decodes func and range-checks
// entry_index against the pool size, then wait in a two-deep queue for the pool
// engine, so the input side keeps taking transfers, up to three held in the front
// stage and queue, while the engine works or the output is stalled. Engine steps follow
// the registered read of the free-ring and slot memories: unalloc, free, a refused
// alloc and an empty sweep complete straight from idle; a granted alloc reads the ring
// at the head, then writes the slot and gives the result; a sweep of k returned entries
// does one ring read and one slot read per entry, and gives k result transfers with
// last on the final one. Every request gives at least one result transfer; results sit
// in an output register so the engine carries on as soon as the consumer takes them.
// The slot of an entry that was freed without being allocated is undefined. Writing
// the pool entry count (address 0) reinitialises ring, cursors and counts; no clearing
// pass is needed after reset or after a write. Write the register only while the block
// is idle.
module deferred_return_buffer_pool #(
    parameter int POOL_DEPTH = drb_pkg::DEF_POOL_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [drb_pkg::ADDR_W-1:0]  paddr,
    input  logic [drb_pkg::DATA_W-1:0]  pwdata,
    output logic [drb_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic [drb_pkg::SLOT_W-1:0]  slot_index,
    input  logic [drb_pkg::ENTRY_W-1:0] entry_index,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        granted,
    output logic [drb_pkg::ENTRY_W-1:0] entry_out,
    output logic [drb_pkg::SLOT_W-1:0]  slot_out,
    output logic                        slot_valid,
    output logic                        last,
    output logic [drb_pkg::SIZE_W-1:0]  free_count
);
    import drb_pkg::*;

    logic [SIZE_W-1:0] pool_entries_reg;
    logic [SIZE_W-1:0] n_size;
    logic              reg_sel;
    logic              cfg_wr;
    init_t             init;

    logic              q_push;
    logic              q_push_ready;
    op_t               q_push_op;
    logic              q_pop_valid;
    logic              q_pop;
    op_t               q_pop_op;
    res_t              res;

    // APB: no wait states; register index is the word address
    assign pready  = 1'b1;
    assign reg_sel = paddr[2] == REG_POOL_ENTRIES;
    assign cfg_wr  = psel && penable && pwrite && reg_sel;
    assign prdata  = reg_sel ? DATA_W'(pool_entries_reg) : '0;

    // effective size: entry count saturated into 1..POOL_DEPTH
    assign n_size    = eff_size(pool_entries_reg, SIZE_W'(POOL_DEPTH));
    assign init.en   = cfg_wr;
    assign init.size = eff_size(pwdata[SIZE_W-1:0], SIZE_W'(POOL_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_entries_reg <= POOL_ENTRIES_RST;
        end
        else if (cfg_wr)
        begin
            pool_entries_reg <= pwdata[SIZE_W-1:0];
        end
    end

    drb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .slot_index  (slot_index),
        .entry_index (entry_index),
        .n_size      (n_size),
        .q_ready     (q_push_ready),
        .q_push      (q_push),
        .q_op        (q_push_op)
    );

    drb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ready (q_push_ready),
        .push_op    (q_push_op),
        .pop_valid  (q_pop_valid),
        .pop        (q_pop),
        .pop_op     (q_pop_op)
    );

    drb_back #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .init      (init),
        .n_size    (n_size),
        .q_valid   (q_pop_valid),
        .q_op      (q_pop_op),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    assign granted    = res.granted;
    assign entry_out  = res.entry_out;
    assign slot_out   = res.slot_out;
    assign slot_valid = res.slot_valid;
    assign last       = res.last;
    assign free_count = res.free_count;

endmodule

[sim/tb_top.sv]
// Self-checking bench for deferred_return_buffer_pool: directed table, then random phases.
// Depends on rtl/drb_pkg.sv and the RTL of the pool; predicts every result transfer itself.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import drb_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
    localparam int unsigned HOLD_CYCLES    = 200;   // long receiver hold-off
    localparam int unsigned MAX_GAP        = 11;
    localparam int unsigned SETTLE_CYCLES  = 20;
    localparam logic [ADDR_W-1:0] POOL_ENTRIES_ADDR = '0;  // byte address of entry count

    typedef enum logic {ROW_OP, ROW_SIZE} row_kind_t;

    // one line of the directed table
    typedef struct {
        row_kind_t          kind;
        func_t              op;
        logic [SLOT_W-1:0]  slot;
        logic [ENTRY_W-1:0] entry;
        logic [SIZE_W-1:0]  size;
        bit                 typed;   // want holds a hand-written answer
        res_t               want;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          func;
    logic [SLOT_W-1:0]   slot_index;
    logic [ENTRY_W-1:0]  entry_index;
    logic                out_valid;
    logic                out_ready;
    logic                granted;
    logic [ENTRY_W-1:0]  entry_out;
    logic [SLOT_W-1:0]   slot_out;
    logic                slot_valid;
    logic                last;
    logic [SIZE_W-1:0]   free_count;

    // predictor state: own copy of the pool
    logic [ENTRY_W-1:0]  ring      [0:DEF_POOL_DEPTH-1];
    logic [SLOT_W-1:0]   slot_mem  [0:DEF_POOL_DEPTH-1];
    bit                  written   [0:DEF_POOL_DEPTH-1];  // slot recorded since last size write
    int unsigned         cfg_size;
    int unsigned         head_pos;
    int unsigned         tail_pos;
    int unsigned         trail_pos;
    int unsigned         avail;
    int unsigned         returned;

    res_t                due_replies [$];   // predicted result transfers, oldest first
    logic [ENTRY_W-1:0]  held [$];          // entries handed out, used to form sane frees
    plan_row_t           plan [$];

    int unsigned         mismatches = 0;
    int unsigned         stuck_cycles = 0;
    bit                  quiet = 1'b0;      // no idling on either side
    bit                  hold_off_req = 1'b0;

    deferred_return_buffer_pool dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .slot_index  (slot_index),
        .entry_index (entry_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .granted     (granted),
        .entry_out   (entry_out),
        .slot_out    (slot_out),
        .slot_valid  (slot_valid),
        .last        (last),
        .free_count  (free_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // effective pool size: register saturated into 1..depth
    function automatic int unsigned pool_limit();
        if (cfg_size == 0)
            return 1;
        if (cfg_size > DEF_POOL_DEPTH)
            return DEF_POOL_DEPTH;
        return cfg_size;
    endfunction

    function automatic int unsigned busy_entries();
        int unsigned n;
        n = pool_limit();
        return (avail + returned < n) ? n - avail - returned : 0;
    endfunction

    function automatic int unsigned step_ptr(input int unsigned p, input int unsigned n);
        return (p + 1 >= n) ? 0 : p + 1;
    endfunction

    function automatic res_t mk_res(input logic g, input logic [ENTRY_W-1:0] eo,
                                    input logic [SLOT_W-1:0] so, input logic sv,
                                    input logic l, input logic [SIZE_W-1:0] fc);
        res_t r;
        r.granted    = g;
        r.entry_out  = eo;
        r.slot_out   = so;
        r.slot_valid = sv;
        r.last       = l;
        r.free_count = fc;
        return r;
    endfunction

    // ring, cursors and counts as after reset; slot memory keeps its contents
    task automatic reinit_pool(input int unsigned size);
        cfg_size = size & 7'h7f;
        for (int i = 0; i < DEF_POOL_DEPTH; i++)
        begin
            ring[i]    = ENTRY_W'(i);
            written[i] = 1'b0;
        end
        head_pos  = 0;
        tail_pos  = 0;
        trail_pos = 0;
        avail     = pool_limit();
        returned  = 0;
        held.delete();
    endtask

    // one accepted request: update pool copy, queue the transfers it must cause
    task automatic apply_pool_op(input func_t f, input logic [SLOT_W-1:0] s,
                                 input logic [ENTRY_W-1:0] e);
        int unsigned        n;
        int unsigned        outst;
        int unsigned        cnt;
        logic [ENTRY_W-1:0] ent;
        n     = pool_limit();
        outst = busy_entries();
        case (f)
            FUNC_ALLOC:
            begin
                if (avail == 0)
                    due_replies.push_back(mk_res(1'b0, '0, '0, 1'b0, 1'b1, SIZE_W'(avail)));
                else
                begin
                    avail--;
                    ent           = ring[head_pos];
                    slot_mem[ent] = s;
                    written[ent]  = 1'b1;
                    held.push_back(ent);
                    head_pos = step_ptr(head_pos, n);
                    due_replies.push_back(mk_res(1'b1, ent, '0, 1'b0, 1'b1, SIZE_W'(avail)));
                end
            end
            FUNC_UNALLOC:
            begin
                if (outst == 0)
                    due_replies.push_back(mk_res(1'b0, '0, '0, 1'b0, 1'b1, SIZE_W'(avail)));
                else
                begin
                    avail++;
                    head_pos = (head_pos > 0) ? head_pos - 1 : n - 1;
                    if (held.size() != 0)
                        void'(held.pop_back());
                    due_replies.push_back(mk_res(1'b1, '0, '0, 1'b0, 1'b1, SIZE_W'(avail)));
                end
            end
            FUNC_FREE:
            begin
                // duplicates and foreign entries go through unnoticed
                if (outst == 0 || e >= n)
                    due_replies.push_back(mk_res(1'b0, '0, '0, 1'b0, 1'b1, SIZE_W'(avail)));
                else
                begin
                    ring[tail_pos] = e;
                    returned++;
                    tail_pos = step_ptr(tail_pos, n);
                    due_replies.push_back(mk_res(1'b1, '0, '0, 1'b0, 1'b1, SIZE_W'(avail)));
                end
            end
            default:
            begin
                if (returned == 0)
                    due_replies.push_back(mk_res(1'b1, '0, '0, 1'b0, 1'b1, SIZE_W'(avail)));
                else
                begin
                    cnt = returned;
                    for (int unsigned k = 0; k < cnt; k++)
                    begin
                        ent = ring[trail_pos];
                        avail++;
                        due_replies.push_back(mk_res(1'b1, '0, slot_mem[ent], 1'b1,
                                                     (k + 1 == cnt), SIZE_W'(avail)));
                        trail_pos = step_ptr(trail_pos, n);
                    end
                    returned = 0;
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------- drivers

    // offer one request after a random gap; predict it on the accepting edge
    task automatic send_op(input func_t f, input logic [SLOT_W-1:0] s,
                           input logic [ENTRY_W-1:0] e);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func        <= f;
        slot_index  <= s;
        entry_index <= e;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        apply_pool_op(f, s, e);
    endtask

    // entry count write and read-back, only once every predicted transfer is in
    task automatic write_pool_entries(input logic [SIZE_W-1:0] v);
        logic [DATA_W-1:0] rd;
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POOL_ENTRIES_ADDR;
        pwdata  <= DATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // back-to-back read of the same register
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== DATA_W'(v))
        begin
            $error("prdata: expected %0h, got %0h", DATA_W'(v), rd);
            mismatches++;
        end
        reinit_pool(v);
    endtask

    // random request; most frees name an entry that is really out
    task automatic pick_random_op(input int unsigned sweep_pct, output func_t f,
                                  output logic [SLOT_W-1:0] s, output logic [ENTRY_W-1:0] e);
        int unsigned r;
        int unsigned n;
        int unsigned idx;
        n = pool_limit();
        r = $urandom_range(0, 99);
        if (r < 45)
            f = FUNC_ALLOC;
        else if (r < 55)
            f = FUNC_UNALLOC;
        else if (r < 100 - sweep_pct)
            f = FUNC_FREE;
        else
            f = FUNC_SWEEP;
        case ($urandom_range(0, 9))
            0:       s = '0;
            1:       s = '1;
            default: s = $urandom;
        endcase
        if (f == FUNC_FREE && held.size() != 0 && $urandom_range(0, 99) < 85)
        begin
            idx = $urandom_range(0, held.size() - 1);
            e   = held[idx];
            held.delete(idx);
        end
        else
        begin
            e = ENTRY_W'($urandom_range(0, DEF_POOL_DEPTH - 1));
            // never let an entry with no recorded slot reach the ring
            if (f == FUNC_FREE && busy_entries() != 0 && e < n && !written[e])
            begin
                for (int i = n - 1; i >= 0; i--)
                    if (written[i])
                        e = ENTRY_W'(i);
            end
        end
    endtask

    // ---------------------------------------------------------------- directed table

    function automatic plan_row_t op_row(input func_t f, input logic [SLOT_W-1:0] s,
                                         input logic [ENTRY_W-1:0] e);
        plan_row_t r;
        r.kind  = ROW_OP;
        r.op    = f;
        r.slot  = s;
        r.entry = e;
        r.size  = '0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // single-transfer row with its answer typed in
    function automatic plan_row_t fixed_row(input func_t f, input logic [SLOT_W-1:0] s,
                                            input logic [ENTRY_W-1:0] e, input logic g,
                                            input logic [ENTRY_W-1:0] eo,
                                            input logic [SLOT_W-1:0] so, input logic sv,
                                            input logic [SIZE_W-1:0] fc);
        plan_row_t r;
        r       = op_row(f, s, e);
        r.typed = 1'b1;
        r.want  = mk_res(g, eo, so, sv, 1'b1, fc);
        return r;
    endfunction

    function automatic plan_row_t size_row(input logic [SIZE_W-1:0] v);
        plan_row_t r;
        r      = op_row(FUNC_ALLOC, '0, '0);
        r.kind = ROW_SIZE;
        r.size = v;
        return r;
    endfunction

    task automatic build_plan();
        // from reset, 64 entries: refusals and empty sweep
        plan.push_back(fixed_row(FUNC_UNALLOC, '0, '0, 0, 0, '0, 0, 64));
        plan.push_back(fixed_row(FUNC_FREE, '0, '0, 0, 0, '0, 0, 64));
        plan.push_back(fixed_row(FUNC_SWEEP, '0, '0, 1, 0, '0, 0, 64));
        // alloc, undo, re-alloc hands the same entry out again
        plan.push_back(fixed_row(FUNC_ALLOC, 32'h0000_0000, '0, 1, 0, '0, 0, 63));
        plan.push_back(fixed_row(FUNC_ALLOC, 32'hFFFF_FFFF, '1, 1, 1, '0, 0, 62));
        plan.push_back(fixed_row(FUNC_UNALLOC, '0, '0, 1, 0, '0, 0, 63));
        plan.push_back(fixed_row(FUNC_ALLOC, 32'hA5A5_A5A5, '0, 1, 1, '0, 0, 62));
        plan.push_back(fixed_row(FUNC_FREE, '0, 6'd1, 1, 0, '0, 0, 62));
        plan.push_back(fixed_row(FUNC_FREE, '0, 6'd0, 1, 0, '0, 0, 62));
        plan.push_back(op_row(FUNC_SWEEP, '0, '0));
        // nothing outstanding
        plan.push_back(fixed_row(FUNC_FREE, '0, 6'd63, 0, 0, '0, 0, 64));
        plan.push_back(op_row(FUNC_ALLOC, 32'h1357_9BDF, '0));
        // single-entry pool
        plan.push_back(size_row(7'd1));
        plan.push_back(fixed_row(FUNC_ALLOC, 32'h1234_5678, '0, 1, 0, '0, 0, 0));
        plan.push_back(fixed_row(FUNC_ALLOC, 32'hFFFF_FFFF, '0, 0, 0, '0, 0, 0));
        plan.push_back(fixed_row(FUNC_FREE, '0, 6'd1, 0, 0, '0, 0, 0));
        plan.push_back(fixed_row(FUNC_FREE, '0, 6'd63, 0, 0, '0, 0, 0));
        plan.push_back(fixed_row(FUNC_FREE, '0, 6'd0, 1, 0, '0, 0, 0));
        plan.push_back(fixed_row(FUNC_FREE, '0, 6'd0, 0, 0, '0, 0, 0));
        plan.push_back(fixed_row(FUNC_SWEEP, '0, '0, 1, 0, 32'h1234_5678, 1, 1));
        plan.push_back(fixed_row(FUNC_UNALLOC, '0, '0, 0, 0, '0, 0, 1));
        plan.push_back(op_row(FUNC_ALLOC, 32'hDEAD_BEEF, '0));
        plan.push_back(op_row(FUNC_UNALLOC, '0, '0));
        // full pool again; a duplicate free is taken and swept twice
        plan.push_back(size_row(7'd64));
        plan.push_back(op_row(FUNC_ALLOC, 32'h0BAD_F00D, '0));
        plan.push_back(op_row(FUNC_ALLOC, 32'h0000_0001, '0));
        plan.push_back(op_row(FUNC_FREE, '0, 6'd0));
        plan.push_back(op_row(FUNC_FREE, '0, 6'd0));
        plan.push_back(op_row(FUNC_SWEEP, '0, '0));
    endtask

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string name, input logic [SLOT_W-1:0] want,
                                        input logic [SLOT_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // receiver: random stall per transfer, one long hold-off on request
    initial
    begin
        int unsigned stall;
        res_t        want;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            else
                stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (due_replies.size() == 0)
            begin
                $error("result transfer with nothing expected: entry_out %0h slot_out %0h",
                       entry_out, slot_out);
                mismatches++;
            end
            else
            begin
                want = due_replies.pop_front();
                check_field("granted", SLOT_W'(want.granted), SLOT_W'(granted));
                check_field("entry_out", SLOT_W'(want.entry_out), SLOT_W'(entry_out));
                check_field("slot_out", want.slot_out, slot_out);
                check_field("slot_valid", SLOT_W'(want.slot_valid), SLOT_W'(slot_valid));
                check_field("last", SLOT_W'(want.last), SLOT_W'(last));
                check_field("free_count", SLOT_W'(want.free_count), SLOT_W'(free_count));
            end
        end
    end

    // watchdog: any stretch without a single transfer is a hang
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles <= 0;
            else if (stuck_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        int unsigned        sizes [8];
        func_t              f;
        logic [SLOT_W-1:0]  s;
        logic [ENTRY_W-1:0] e;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        func        = FUNC_ALLOC;
        slot_index  = '0;
        entry_index = '0;
        sizes = '{64, 2, 1, 17, 64, 5, 40, 63};
        reinit_pool(POOL_ENTRIES_RST);
        build_plan();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_SIZE)
                write_pool_entries(plan[i].size);
            else
            begin
                send_op(plan[i].op, plan[i].slot, plan[i].entry);
                // hand-written answer replaces the prediction for this transfer
                if (plan[i].typed)
                    due_replies[due_replies.size() - 1] = plan[i].want;
            end
        end

        // random phases, each behind a size write with the pool drained
        foreach (sizes[p])
        begin
            write_pool_entries(SIZE_W'(sizes[p]));
            quiet = (p == 3 || p == 6);
            if (p == 0)
                hold_off_req = 1'b1;  // output stalls, block fills and pushes back
            repeat (56)
            begin
                pick_random_op((p == 4) ? 3 : 15, f, s, e);
                send_op(f, s, e);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
